### rtl/rost_pkg.sv
package rost_pkg;

   // Word, product, accumulator, distance and command widths.
   localparam int WORD_W = 32;
   localparam int PROD_W = 64;
   localparam int ACC_W  = 66;
   localparam int DIST_W = 31;
   localparam int CMD_W  = 3;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic signed [ACC_W-1:0]  acc_type;

   // Item command codes.
   localparam logic [CMD_W-1:0] CMD_CENTER = 3'd0;
   localparam logic [CMD_W-1:0] CMD_AXIS_U = 3'd1;
   localparam logic [CMD_W-1:0] CMD_AXIS_V = 3'd2;
   localparam logic [CMD_W-1:0] CMD_HALF   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_ORIGIN = 3'd4;
   localparam logic [CMD_W-1:0] CMD_TEST   = 3'd5;

   localparam word_type WORD_MAX = 32'sh7fff_ffff;
   localparam word_type WORD_MIN = 32'sh8000_0000;

   // Vector that feeds one side of the multiplier.
   typedef enum logic [2:0] {
      VEC_U,
      VEC_V,
      VEC_W,
      VEC_DIR,
      VEC_OFF
   } vec_sel_type;

   // Accumulator operations.
   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_SUB,
      ACC_LOAD_SH,
      ACC_ADD_SH
   } acc_op_type;

   // Write-back targets for the accumulator.
   typedef enum logic [1:0] {
      WB_NONE,
      WB_W,
      WB_FP,
      WB_EP
   } wb_op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load_vec;
      logic        calc_off;
      logic        mul_en;
      vec_sel_type mul_a_vec;
      logic [1:0]  mul_a_comp;
      vec_sel_type mul_b_vec;
      logic [1:0]  mul_b_comp;
      acc_op_type  acc_op;
      wb_op_type   wb_op;
      logic [1:0]  idx;
      logic        set_miss;
      logic        div_start;
      logic        div_hi;
      logic        t_lo_save;
      logic        slab_upd;
      logic        t_init;
      logic        res_load;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
      logic par_miss;
   } dp_sts_type;

   // Saturate an accumulator value to a signed word.
   function automatic word_type sat_word(input acc_type v);
      word_type r;
      if ((&v[ACC_W-1:WORD_W-1]) || !(|v[ACC_W-1:WORD_W-1])) begin
         r = v[WORD_W-1:0];
      end else if (v[ACC_W-1]) begin
         r = WORD_MIN;
      end else begin
         r = WORD_MAX;
      end
      return r;
   endfunction

   // Next axis index, wrapping after the third.
   function automatic logic [1:0] inc3(input logic [1:0] k);
      logic [1:0] r;
      if (k == 2'd2) begin
         r = 2'd0;
      end else begin
         r = k + 2'd1;
      end
      return r;
   endfunction

endpackage

### rtl/rost_if.sv
// Request channel: one command and one 3-vector per item.
interface rost_req_if;
   logic                         valid;
   logic                         ready;
   logic [rost_pkg::CMD_W-1:0]   cmd;
   logic signed [rost_pkg::WORD_W-1:0] comp_x;
   logic signed [rost_pkg::WORD_W-1:0] comp_y;
   logic signed [rost_pkg::WORD_W-1:0] comp_z;

   modport source (output valid, cmd, comp_x, comp_y, comp_z, input ready);
   modport sink (input valid, cmd, comp_x, comp_y, comp_z, output ready);
endinterface

// Response channel: hit flag and distance per test item.
interface rost_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        hit;
   logic [rost_pkg::DIST_W-1:0] distance;

   modport source (output valid, hit, distance, input ready);
   modport sink (input valid, hit, distance, output ready);
endinterface

### rtl/rost_div.sv
// Signed restoring divider, one quotient bit per cycle, saturating to a word.
module rost_div #(
   parameter int NUM_W = 49
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [NUM_W-1:0]     num,
   input  rost_pkg::word_type          den,
   output logic                        done,
   output rost_pkg::word_type          quot
);

   localparam int CMP_W = (NUM_W > 64) ? NUM_W : 64;
   localparam int W     = rost_pkg::WORD_W;

   typedef enum logic [1:0] {
      D_IDLE,
      D_CHECK,
      D_RUN,
      D_FINISH
   } state_type;

   state_type          state_ff, state_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [NUM_W-1:0]   num_mag_ff, num_mag_in;
   logic [W-1:0]       den_mag_ff, den_mag_in;
   logic               neg_ff, neg_in;
   logic               ovf_ff, ovf_in;
   logic [W-1:0]       rem_ff, rem_in;
   logic [W-1:0]       quo_ff, quo_in;
   logic               done_ff, done_in;
   rost_pkg::word_type quot_ff, quot_in;

   logic [W:0]         rem_sh;
   logic               ge;
   logic [CMP_W-1:0]   num_ext;
   logic [CMP_W-1:0]   den_ext;

   // Shift-and-subtract step and the overflow check.
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[W-1]};
      ge      = rem_sh >= {1'b0, den_mag_ff};
      num_ext = {{(CMP_W-NUM_W){1'b0}}, num_mag_ff};
      den_ext = {{(CMP_W-W){1'b0}}, den_mag_ff} << W;
   end

   // Next-state logic.
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      num_mag_in = num_mag_ff;
      den_mag_in = den_mag_ff;
      neg_in     = neg_ff;
      ovf_in     = ovf_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      done_in    = 1'b0;
      quot_in    = quot_ff;
      unique case (state_ff)
         D_IDLE: begin
            if (start) begin
               num_mag_in = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
               den_mag_in = den[W-1] ? W'(-den) : W'(den);
               neg_in     = num[NUM_W-1] ^ den[W-1];
               state_in   = D_CHECK;
            end
         end
         D_CHECK: begin
            ovf_in   = num_ext >= den_ext;
            rem_in   = {{(2*W-NUM_W){1'b0}}, num_mag_ff[NUM_W-1:W]};
            quo_in   = num_mag_ff[W-1:0];
            cnt_in   = 5'd31;
            state_in = D_RUN;
         end
         D_RUN: begin
            rem_in = ge ? W'(rem_sh - {1'b0, den_mag_ff}) : rem_sh[W-1:0];
            quo_in = {quo_ff[W-2:0], ge};
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = D_FINISH;
            end
         end
         D_FINISH: begin
            if (neg_ff) begin
               if (ovf_ff || (quo_ff > 32'h8000_0000)) begin
                  quot_in = rost_pkg::WORD_MIN;
               end else begin
                  quot_in = -$signed(quo_ff);
               end
            end else begin
               if (ovf_ff || quo_ff[W-1]) begin
                  quot_in = rost_pkg::WORD_MAX;
               end else begin
                  quot_in = $signed(quo_ff);
               end
            end
            done_in  = 1'b1;
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff     <= cnt_in;
      num_mag_ff <= num_mag_in;
      den_mag_ff <= den_mag_in;
      neg_ff     <= neg_in;
      ovf_ff     <= ovf_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      quot_ff    <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

### rtl/rost_dp.sv
// Datapath: vector state, shared multiplier, accumulator, divider and slab logic.
module rost_dp #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rost_pkg::dp_cmd_type                dp_cmd,
   output rost_pkg::dp_sts_type                dp_sts,
   input  logic [rost_pkg::CMD_W-1:0]          req_cmd,
   input  rost_pkg::word_type                  req_comp_x,
   input  rost_pkg::word_type                  req_comp_y,
   input  rost_pkg::word_type                  req_comp_z,
   output logic                                rsp_hit,
   output logic [rost_pkg::DIST_W-1:0]         rsp_distance
);

   localparam int NUM_W = 33 + FRAC_BITS;
   localparam int W     = rost_pkg::WORD_W;

   rost_pkg::word_type center_ff [3], center_in [3];
   rost_pkg::word_type axis_u_ff [3], axis_u_in [3];
   rost_pkg::word_type axis_v_ff [3], axis_v_in [3];
   rost_pkg::word_type half_ff   [3], half_in   [3];
   rost_pkg::word_type start_ff  [3], start_in  [3];
   rost_pkg::word_type dir_ff    [3], dir_in    [3];
   rost_pkg::word_type off_ff    [3], off_in    [3];
   rost_pkg::word_type axis_w_ff [3], axis_w_in [3];
   rost_pkg::word_type fp_ff     [3], fp_in     [3];
   rost_pkg::word_type ep_ff     [3], ep_in     [3];

   logic signed [rost_pkg::PROD_W-1:0] prod_ff, prod_in, prod_sh;
   rost_pkg::acc_type  acc_ff, acc_in;
   rost_pkg::word_type t_lo_ff, t_lo_in;
   rost_pkg::word_type tmin_ff, tmin_in;
   rost_pkg::word_type tmax_ff, tmax_in;
   logic               miss_ff, miss_in;
   logic               hit_ff, hit_in;
   logic [rost_pkg::DIST_W-1:0] dist_ff, dist_in;

   rost_pkg::word_type op_a, op_b;
   rost_pkg::word_type ep_k, half_k, fp_k;
   logic signed [W:0]  lo, hi;
   logic signed [NUM_W-1:0] div_num;
   rost_pkg::word_type div_den;
   logic               div_done;
   rost_pkg::word_type quot;
   rost_pkg::word_type t_mn, t_mx;
   logic               res_hit;

   // Multiplier operand selection.
   always_comb begin
      unique case (dp_cmd.mul_a_vec)
         rost_pkg::VEC_U:   op_a = axis_u_ff[dp_cmd.mul_a_comp];
         rost_pkg::VEC_V:   op_a = axis_v_ff[dp_cmd.mul_a_comp];
         rost_pkg::VEC_W:   op_a = axis_w_ff[dp_cmd.mul_a_comp];
         rost_pkg::VEC_DIR: op_a = dir_ff[dp_cmd.mul_a_comp];
         rost_pkg::VEC_OFF: op_a = off_ff[dp_cmd.mul_a_comp];
         default:           op_a = '0;
      endcase
      unique case (dp_cmd.mul_b_vec)
         rost_pkg::VEC_U:   op_b = axis_u_ff[dp_cmd.mul_b_comp];
         rost_pkg::VEC_V:   op_b = axis_v_ff[dp_cmd.mul_b_comp];
         rost_pkg::VEC_W:   op_b = axis_w_ff[dp_cmd.mul_b_comp];
         rost_pkg::VEC_DIR: op_b = dir_ff[dp_cmd.mul_b_comp];
         rost_pkg::VEC_OFF: op_b = off_ff[dp_cmd.mul_b_comp];
         default:           op_b = '0;
      endcase
   end

   // Slab bounds for the current axis and the divider operands.
   always_comb begin
      ep_k    = ep_ff[dp_cmd.idx];
      half_k  = half_ff[dp_cmd.idx];
      fp_k    = fp_ff[dp_cmd.idx];
      lo      = {ep_k[W-1], ep_k} + {half_k[W-1], half_k};
      hi      = {ep_k[W-1], ep_k} - {half_k[W-1], half_k};
      div_num = dp_cmd.div_hi ? {hi, {FRAC_BITS{1'b0}}} : {lo, {FRAC_BITS{1'b0}}};
      div_den = (fp_k == '0) ? 32'sd1 : fp_k;
      dp_sts.par_miss = (fp_k == '0) && (lo[W] || (!hi[W] && (hi != '0)));
      dp_sts.div_done = div_done;
   end

   rost_div #(
      .NUM_W(NUM_W)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(dp_cmd.div_start),
      .num  (div_num),
      .den  (div_den),
      .done (div_done),
      .quot (quot)
   );

   // Entry and exit of the current slab: the lesser and greater of the two quotients.
   always_comb begin
      t_mn    = (t_lo_ff < quot) ? t_lo_ff : quot;
      t_mx    = (t_lo_ff < quot) ? quot : t_lo_ff;
      res_hit = !miss_ff && !(tmax_ff[W-1] || (tmin_ff > tmax_ff));
   end

   // Next values of all datapath registers.
   always_comb begin
      center_in = center_ff;
      axis_u_in = axis_u_ff;
      axis_v_in = axis_v_ff;
      half_in   = half_ff;
      start_in  = start_ff;
      dir_in    = dir_ff;
      off_in    = off_ff;
      axis_w_in = axis_w_ff;
      fp_in     = fp_ff;
      ep_in     = ep_ff;
      prod_in   = prod_ff;
      acc_in    = acc_ff;
      t_lo_in   = t_lo_ff;
      tmin_in   = tmin_ff;
      tmax_in   = tmax_ff;
      miss_in   = miss_ff;
      hit_in    = hit_ff;
      dist_in   = dist_ff;
      prod_sh   = prod_ff >>> FRAC_BITS;

      // Store the item's vector in the register its command selects.
      if (dp_cmd.load_vec) begin
         unique case (req_cmd)
            rost_pkg::CMD_CENTER: center_in = '{req_comp_x, req_comp_y, req_comp_z};
            rost_pkg::CMD_AXIS_U: axis_u_in = '{req_comp_x, req_comp_y, req_comp_z};
            rost_pkg::CMD_AXIS_V: axis_v_in = '{req_comp_x, req_comp_y, req_comp_z};
            rost_pkg::CMD_HALF:   half_in   = '{req_comp_x, req_comp_y, req_comp_z};
            rost_pkg::CMD_ORIGIN: start_in  = '{req_comp_x, req_comp_y, req_comp_z};
            rost_pkg::CMD_TEST:   dir_in    = '{req_comp_x, req_comp_y, req_comp_z};
            default: ;
         endcase
      end

      // Offset from ray origin to box center.
      if (dp_cmd.calc_off) begin
         for (int i = 0; i < 3; i++) begin
            off_in[i] = rost_pkg::sat_word(rost_pkg::acc_type'(center_ff[i])
                                           - rost_pkg::acc_type'(start_ff[i]));
         end
      end

      if (dp_cmd.mul_en) begin
         prod_in = op_a * op_b;
      end

      // Accumulator.
      unique case (dp_cmd.acc_op)
         rost_pkg::ACC_HOLD:    acc_in = acc_ff;
         rost_pkg::ACC_LOAD:    acc_in = {{2{prod_ff[63]}}, prod_ff};
         rost_pkg::ACC_SUB:     acc_in = acc_ff - {{2{prod_ff[63]}}, prod_ff};
         rost_pkg::ACC_LOAD_SH: acc_in = {{2{prod_sh[63]}}, prod_sh};
         rost_pkg::ACC_ADD_SH:  acc_in = acc_ff + {{2{prod_sh[63]}}, prod_sh};
         default:               acc_in = acc_ff;
      endcase

      // Write-back of cross product components and projections.
      unique case (dp_cmd.wb_op)
         rost_pkg::WB_NONE: ;
         rost_pkg::WB_W:    axis_w_in[dp_cmd.idx] = rost_pkg::sat_word(acc_ff >>> FRAC_BITS);
         rost_pkg::WB_FP:   fp_in[dp_cmd.idx] = rost_pkg::sat_word(acc_ff);
         rost_pkg::WB_EP:   ep_in[dp_cmd.idx] = rost_pkg::sat_word(acc_ff);
         default: ;
      endcase

      // Slab interval bookkeeping.
      if (dp_cmd.t_init) begin
         tmin_in = rost_pkg::WORD_MIN;
         tmax_in = rost_pkg::WORD_MAX;
         miss_in = 1'b0;
      end
      if (dp_cmd.set_miss) begin
         miss_in = 1'b1;
      end
      if (dp_cmd.t_lo_save) begin
         t_lo_in = quot;
      end
      if (dp_cmd.slab_upd) begin
         tmin_in = (t_mn > tmin_ff) ? t_mn : tmin_ff;
         tmax_in = (t_mx < tmax_ff) ? t_mx : tmax_ff;
      end

      // Result register.
      if (dp_cmd.res_load) begin
         hit_in = res_hit;
         if (!res_hit) begin
            dist_in = '0;
         end else if (tmin_ff[W-1]) begin
            dist_in = tmax_ff[rost_pkg::DIST_W-1:0];
         end else begin
            dist_in = tmin_ff[rost_pkg::DIST_W-1:0];
         end
      end
   end

   // Registers; the box vectors and ray origin reset to zero, the direction does not.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            center_ff[i] <= '0;
            axis_u_ff[i] <= '0;
            axis_v_ff[i] <= '0;
            half_ff[i]   <= '0;
            start_ff[i]  <= '0;
         end
         miss_ff <= 1'b0;
      end else begin
         center_ff <= center_in;
         axis_u_ff <= axis_u_in;
         axis_v_ff <= axis_v_in;
         half_ff   <= half_in;
         start_ff  <= start_in;
         miss_ff   <= miss_in;
      end
      dir_ff    <= dir_in;
      off_ff    <= off_in;
      axis_w_ff <= axis_w_in;
      fp_ff     <= fp_in;
      ep_ff     <= ep_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      t_lo_ff   <= t_lo_in;
      tmin_ff   <= tmin_in;
      tmax_ff   <= tmax_in;
      hit_ff    <= hit_in;
      dist_ff   <= dist_in;
   end

   assign rsp_hit      = hit_ff;
   assign rsp_distance = dist_ff;

endmodule

### rtl/rost_ctrl.sv
// Controller: sequences cross product, projections and the six slab divisions.
module rost_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [rost_pkg::CMD_W-1:0]  req_cmd,
   output logic                        req_ready,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output rost_pkg::dp_cmd_type        dp_cmd,
   input  rost_pkg::dp_sts_type        dp_sts
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_OFF,
      S_CR_M1,
      S_CR_M2,
      S_CR_SUB,
      S_CR_WB,
      S_DOT_M,
      S_DOT_ACC,
      S_DOT_WB,
      S_SLAB_CHK,
      S_DIV_LO,
      S_DIV_HI,
      S_SLAB_UPD,
      S_FINAL
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] k_ff, k_in;
   logic [1:0] j_ff, j_in;
   logic       phase_ff, phase_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       out_free;

   // Box axis used for projection k.
   function automatic rost_pkg::vec_sel_type axis_sel(input logic [1:0] k);
      rost_pkg::vec_sel_type r;
      unique case (k)
         2'd0:    r = rost_pkg::VEC_U;
         2'd1:    r = rost_pkg::VEC_V;
         default: r = rost_pkg::VEC_W;
      endcase
      return r;
   endfunction

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Sequencer and datapath commands.
   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      j_in         = j_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      dp_cmd       = '0;
      dp_cmd.idx   = k_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               dp_cmd.load_vec = 1'b1;
               if (req_cmd == rost_pkg::CMD_TEST) begin
                  state_in = S_OFF;
               end
            end
         end
         S_OFF: begin
            dp_cmd.calc_off = 1'b1;
            k_in            = 2'd0;
            state_in        = S_CR_M1;
         end
         // Third axis: u[a]*v[b] - u[b]*v[a] per component.
         S_CR_M1: begin
            dp_cmd.mul_en     = 1'b1;
            dp_cmd.mul_a_vec  = rost_pkg::VEC_U;
            dp_cmd.mul_a_comp = rost_pkg::inc3(k_ff);
            dp_cmd.mul_b_vec  = rost_pkg::VEC_V;
            dp_cmd.mul_b_comp = rost_pkg::inc3(rost_pkg::inc3(k_ff));
            state_in          = S_CR_M2;
         end
         S_CR_M2: begin
            dp_cmd.mul_en     = 1'b1;
            dp_cmd.mul_a_vec  = rost_pkg::VEC_U;
            dp_cmd.mul_a_comp = rost_pkg::inc3(rost_pkg::inc3(k_ff));
            dp_cmd.mul_b_vec  = rost_pkg::VEC_V;
            dp_cmd.mul_b_comp = rost_pkg::inc3(k_ff);
            dp_cmd.acc_op     = rost_pkg::ACC_LOAD;
            state_in          = S_CR_SUB;
         end
         S_CR_SUB: begin
            dp_cmd.acc_op = rost_pkg::ACC_SUB;
            state_in      = S_CR_WB;
         end
         S_CR_WB: begin
            dp_cmd.wb_op = rost_pkg::WB_W;
            if (k_ff == 2'd2) begin
               k_in     = 2'd0;
               j_in     = 2'd0;
               phase_in = 1'b0;
               state_in = S_DOT_M;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = S_CR_M1;
            end
         end
         // Projections: direction first, then the offset.
         S_DOT_M: begin
            dp_cmd.mul_en     = 1'b1;
            dp_cmd.mul_a_vec  = axis_sel(k_ff);
            dp_cmd.mul_a_comp = j_ff;
            dp_cmd.mul_b_vec  = phase_ff ? rost_pkg::VEC_OFF : rost_pkg::VEC_DIR;
            dp_cmd.mul_b_comp = j_ff;
            if (j_ff == 2'd0) begin
               dp_cmd.acc_op = rost_pkg::ACC_HOLD;
            end else if (j_ff == 2'd1) begin
               dp_cmd.acc_op = rost_pkg::ACC_LOAD_SH;
            end else begin
               dp_cmd.acc_op = rost_pkg::ACC_ADD_SH;
            end
            if (j_ff == 2'd2) begin
               j_in     = 2'd0;
               state_in = S_DOT_ACC;
            end else begin
               j_in = j_ff + 2'd1;
            end
         end
         S_DOT_ACC: begin
            dp_cmd.acc_op = rost_pkg::ACC_ADD_SH;
            state_in      = S_DOT_WB;
         end
         S_DOT_WB: begin
            dp_cmd.wb_op = phase_ff ? rost_pkg::WB_EP : rost_pkg::WB_FP;
            if (k_ff == 2'd2) begin
               k_in = 2'd0;
               if (phase_ff) begin
                  dp_cmd.t_init = 1'b1;
                  state_in      = S_SLAB_CHK;
               end else begin
                  phase_in = 1'b1;
                  state_in = S_DOT_M;
               end
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = S_DOT_M;
            end
         end
         // Slab for axis k: parallel check, then entry and exit quotients.
         S_SLAB_CHK: begin
            if (dp_sts.par_miss) begin
               dp_cmd.set_miss = 1'b1;
               state_in        = S_FINAL;
            end else begin
               dp_cmd.div_start = 1'b1;
               state_in         = S_DIV_LO;
            end
         end
         S_DIV_LO: begin
            if (dp_sts.div_done) begin
               dp_cmd.t_lo_save = 1'b1;
               dp_cmd.div_start = 1'b1;
               dp_cmd.div_hi    = 1'b1;
               state_in         = S_DIV_HI;
            end
         end
         S_DIV_HI: begin
            if (dp_sts.div_done) begin
               state_in = S_SLAB_UPD;
            end
         end
         S_SLAB_UPD: begin
            dp_cmd.slab_upd = 1'b1;
            if (k_ff == 2'd2) begin
               state_in = S_FINAL;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = S_SLAB_CHK;
            end
         end
         S_FINAL: begin
            if (out_free) begin
               dp_cmd.res_load = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, counters and the response valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         k_ff         <= 2'd0;
         j_ff         <= 2'd0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         j_ff         <= j_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/ray_obb_slab_test_unit.sv
// Load items (box center, axes, half extents, ray origin) are stored as they are accepted.
// A test item is worked through offset, cross product, projections and all three
// slabs; each of the six quotients comes from a restoring divider.
// A parallel slab that misses ends the test early.
// One item is in work at a time; a waiting result does not block load items.
// Synchronous active-high reset zeroes the box vectors and ray origin, idles control.
module ray_obb_slab_test_unit #(
   parameter int FRAC_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   rost_req_if.sink   req_chan,
   rost_rsp_if.source rsp_chan
);

   rost_pkg::dp_cmd_type dp_cmd;
   rost_pkg::dp_sts_type dp_sts;

   rost_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_chan.valid),
      .req_cmd  (req_chan.cmd),
      .req_ready(req_chan.ready),
      .rsp_ready(rsp_chan.ready),
      .rsp_valid(rsp_chan.valid),
      .dp_cmd   (dp_cmd),
      .dp_sts   (dp_sts)
   );

   rost_dp #(
      .FRAC_BITS(FRAC_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .dp_cmd      (dp_cmd),
      .dp_sts      (dp_sts),
      .req_cmd     (req_chan.cmd),
      .req_comp_x  (req_chan.comp_x),
      .req_comp_y  (req_chan.comp_y),
      .req_comp_z  (req_chan.comp_z),
      .rsp_hit     (rsp_chan.hit),
      .rsp_distance(rsp_chan.distance)
   );

   // A result is written only into a free output register.
   a_res_free: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.res_load |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("result loaded over a pending item");

   // A loaded result is offered on the next cycle.
   a_res_valid: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.res_load |=> rsp_chan.valid)
      else $error("loaded result not offered");

   // The input stays closed while a division completes.
   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      dp_sts.div_done |-> !req_chan.ready)
      else $error("input open during a test");

endmodule
